@@ hw/rtl/gsbf_pkg.sv @@
// Shared types and constants for the gyro static bias finder.
// No dependencies; every other file of the block but gsbf_div imports this package.
`default_nettype none

package gsbf_pkg;

   localparam int TIME_BITS      = 64;
   localparam int THRESH_BITS    = 32;
   localparam int MIN_DUR_BITS   = 40;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 40;
   localparam int AXIS_BITS      = 2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_QUIET = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_SHORT    = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUIET_RATE_SQUARED = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_DURATION       = 1'b1;

   localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = 32'd1024;
   localparam logic [MIN_DUR_BITS-1:0] MIN_DUR_RESET = 40'd1000000000;

   // axis select for the shared divider
   localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                 capture;
      logic                 update;
      logic                 close_run;
      logic                 div_start;
      logic                 bias_store;
      logic                 emit;
      logic [AXIS_BITS-1:0] axis;
   } gsbf_cmd_type;

   typedef struct packed {
      logic last_item;
      logic result_ok;
      logic div_done;
   } gsbf_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/gyro_static_bias_finder.sv @@
// Top level of the gyro static bias finder: port packing, controller and
// datapath. Uses gsbf_pkg, gsbf_ctrl, gsbf_datapath.
`default_nettype none

// Finds the longest quiet stretch in a trace of timestamped three-axis gyro
// samples and reports the mean rate over it as the static bias. Samples whose
// timestamp does not advance past the last accepted one are dropped and
// counted. A sample is quiet when gx^2+gy^2+gz^2 <= quiet_rate_squared; a
// run that is strictly longer (last minus first timestamp) than the best so
// far replaces it. The item with tlast set closes the open run and yields one
// result item: status in rsp_tuser, and for status ok the per-axis means
// (truncated toward zero), run length, run duration and drop count; the
// trace state then clears. An ordinary sample occupies the block for capture
// (with the squares) and then the run update. The last sample passes through
// capture, update, run close, status check and result load plus, for status
// ok, three passes of the shared bit-serial divider; the result load waits
// while an earlier result is still untaken. The result sits in an output
// register, so the next trace may start while it waits to be taken.
// Configuration is written through csr_*; the user must write it only
// between traces, as the block itself does not enforce this.
module gyro_static_bias_finder #(
   parameter int COUNT_BITS  = 24,
   parameter int SAMPLE_BITS = 16,
   localparam int REQ_RAW_BITS  = gsbf_pkg::TIME_BITS + 3 * SAMPLE_BITS,
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8,
   localparam int RSP_RAW_BITS  = 3 * SAMPLE_BITS + 2 * COUNT_BITS + gsbf_pkg::TIME_BITS,
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // samples in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // timestamp, gyro_x, gyro_y, gyro_z (low to high), zero pad
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,
   input  logic                                req_tlast,
   // result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bias_x, bias_y, bias_z, run_samples, run_duration, dropped_samples
   // (low to high), zero pad
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,
   // status
   output logic [gsbf_pkg::STATUS_BITS-1:0]    rsp_tuser,
   // configuration writes
   input  logic                                csr_we,
   input  logic [gsbf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gsbf_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import gsbf_pkg::*;

   logic [TIME_BITS-1:0]          in_timestamp;
   logic signed [SAMPLE_BITS-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
   logic signed [SAMPLE_BITS-1:0] out_bias_x, out_bias_y, out_bias_z;
   logic [COUNT_BITS-1:0]         out_run_samples, out_dropped_samples;
   logic [TIME_BITS-1:0]          out_run_duration;
   logic [RSP_RAW_BITS-1:0]       rsp_raw;
   gsbf_cmd_type                  cmd;
   gsbf_sts_type                  sts;

   // unpack the request item
   assign in_timestamp = req_tdata[TIME_BITS-1:0];
   assign in_gyro_x    = req_tdata[TIME_BITS +: SAMPLE_BITS];
   assign in_gyro_y    = req_tdata[TIME_BITS + SAMPLE_BITS +: SAMPLE_BITS];
   assign in_gyro_z    = req_tdata[TIME_BITS + 2 * SAMPLE_BITS +: SAMPLE_BITS];

   gsbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   gsbf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .in_timestamp        (in_timestamp),
      .in_gyro_x           (in_gyro_x),
      .in_gyro_y           (in_gyro_y),
      .in_gyro_z           (in_gyro_z),
      .in_last             (req_tlast),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .sts                 (sts),
      .out_status          (rsp_tuser),
      .out_bias_x          (out_bias_x),
      .out_bias_y          (out_bias_y),
      .out_bias_z          (out_bias_z),
      .out_run_samples     (out_run_samples),
      .out_run_duration    (out_run_duration),
      .out_dropped_samples (out_dropped_samples)
   );

   // pack the result item, first field lowest
   assign rsp_raw   = {out_dropped_samples, out_run_duration, out_run_samples,
                       out_bias_z, out_bias_y, out_bias_x};
   assign rsp_tdata = RSP_DATA_BITS'(rsp_raw);

endmodule

`default_nettype wire

@@ hw/rtl/gsbf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by gsbf_datapath for the per-axis means.
`default_nettype none

module gsbf_div #(
   parameter int DIVIDEND_BITS = 40,
   parameter int DIVISOR_BITS  = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  den_ff, den_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         step_in = STEP_BITS'(DIVIDEND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // borrow set: shifted remainder below divisor, keep it
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], ~diff[DIVISOR_BITS]};
         rem_in  = diff[DIVISOR_BITS] ? trial[DIVISOR_BITS-1:0] : diff[DIVISOR_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gsbf_datapath.sv @@
// Datapath: sample capture, squares, run and best-run tracking, config
// registers, bias division and the result register. Uses gsbf_pkg, gsbf_div.
`default_nettype none

module gsbf_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [gsbf_pkg::TIME_BITS-1:0]          in_timestamp,
   input  logic signed [SAMPLE_BITS-1:0]           in_gyro_x,
   input  logic signed [SAMPLE_BITS-1:0]           in_gyro_y,
   input  logic signed [SAMPLE_BITS-1:0]           in_gyro_z,
   input  logic                                    in_last,
   input  logic                                    csr_we,
   input  logic [gsbf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [gsbf_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  gsbf_pkg::gsbf_cmd_type                  cmd,
   output gsbf_pkg::gsbf_sts_type                  sts,
   output logic [gsbf_pkg::STATUS_BITS-1:0]        out_status,
   output logic signed [SAMPLE_BITS-1:0]           out_bias_x,
   output logic signed [SAMPLE_BITS-1:0]           out_bias_y,
   output logic signed [SAMPLE_BITS-1:0]           out_bias_z,
   output logic [COUNT_BITS-1:0]                   out_run_samples,
   output logic [gsbf_pkg::TIME_BITS-1:0]          out_run_duration,
   output logic [COUNT_BITS-1:0]                   out_dropped_samples
);

   import gsbf_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int MAG_BITS = 2 * SAMPLE_BITS;
   localparam int CMP_BITS = (MAG_BITS > THRESH_BITS) ? MAG_BITS : THRESH_BITS;
   localparam logic [1:0] ACC_FULL = 2'd2;
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] BIAS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] BIAS_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'(BIAS_MAX);
   localparam logic [SUM_BITS-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]    acc,
      input logic signed [SAMPLE_BITS-1:0] smp);
      logic signed [SUM_BITS:0] wide;
      wide = (SUM_BITS+1)'(acc) + (SUM_BITS+1)'(smp);
      if (wide[SUM_BITS] != wide[SUM_BITS-1])
         sat_add = wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      else
         sat_add = wide[SUM_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (c == '1) ? c : c + 1'b1;
   endfunction

   // config
   logic [THRESH_BITS-1:0]  thresh_ff;
   logic [MIN_DUR_BITS-1:0] min_dur_ff;

   // captured sample
   logic [TIME_BITS-1:0]          ts_ff;
   logic signed [SAMPLE_BITS-1:0] gx_ff, gy_ff, gz_ff;
   logic                          last_ff;
   logic [MAG_BITS-1:0]           sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [MAG_BITS-1:0]    prod_x, prod_y, prod_z;

   // control state
   logic                  seen_any_ff, seen_any_in;
   logic [1:0]            acc_cnt_ff, acc_cnt_in;
   logic                  in_run_ff, in_run_in;
   logic                  best_valid_ff, best_valid_in;
   logic [COUNT_BITS-1:0] drop_cnt_ff, drop_cnt_in;

   // run and best payload
   logic [TIME_BITS-1:0]       prev_time_ff, prev_time_in;
   logic [TIME_BITS-1:0]       run_start_ff, run_start_in;
   logic [TIME_BITS-1:0]       run_dur_ff, run_dur_in;
   logic signed [SUM_BITS-1:0] run_sum_x_ff, run_sum_x_in;
   logic signed [SUM_BITS-1:0] run_sum_y_ff, run_sum_y_in;
   logic signed [SUM_BITS-1:0] run_sum_z_ff, run_sum_z_in;
   logic [COUNT_BITS-1:0]      run_len_ff, run_len_in;
   logic [TIME_BITS-1:0]       best_dur_ff, best_dur_in;
   logic signed [SUM_BITS-1:0] best_sum_x_ff, best_sum_x_in;
   logic signed [SUM_BITS-1:0] best_sum_y_ff, best_sum_y_in;
   logic signed [SUM_BITS-1:0] best_sum_z_ff, best_sum_z_in;
   logic [COUNT_BITS-1:0]      best_len_ff, best_len_in;

   logic signed [SAMPLE_BITS-1:0] bias_x_ff, bias_y_ff, bias_z_ff, bias_in;

   // result register
   logic [STATUS_BITS-1:0]        rsp_status_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_bias_x_ff, rsp_bias_y_ff, rsp_bias_z_ff;
   logic [COUNT_BITS-1:0]         rsp_len_ff, rsp_drop_ff;
   logic [TIME_BITS-1:0]          rsp_dur_ff;

   logic                       drop, quiet, take_best, do_close;
   logic [MAG_BITS-1:0]        mag2;
   logic [STATUS_BITS-1:0]     status_code;
   logic signed [SUM_BITS-1:0] sel_sum;
   logic [SUM_BITS-1:0]        sel_mag;
   logic [SUM_BITS-1:0]        quotient;
   logic                       div_done;

   assign prod_x = MAG_BITS'(in_gyro_x) * MAG_BITS'(in_gyro_x);
   assign prod_y = MAG_BITS'(in_gyro_y) * MAG_BITS'(in_gyro_y);
   assign prod_z = MAG_BITS'(in_gyro_z) * MAG_BITS'(in_gyro_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= THRESH_RESET;
         min_dur_ff <= MIN_DUR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_QUIET_RATE_SQUARED: thresh_ff  <= csr_data[THRESH_BITS-1:0];
            REG_MIN_DURATION:       min_dur_ff <= csr_data[MIN_DUR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff   <= in_timestamp;
         gx_ff   <= in_gyro_x;
         gy_ff   <= in_gyro_y;
         gz_ff   <= in_gyro_z;
         last_ff <= in_last;
         sq_x_ff <= $unsigned(prod_x);
         sq_y_ff <= $unsigned(prod_y);
         sq_z_ff <= $unsigned(prod_z);
      end
   end

   always_comb begin
      drop      = seen_any_ff && (ts_ff <= prev_time_ff);
      mag2      = sq_x_ff + sq_y_ff + sq_z_ff;
      quiet     = CMP_BITS'(mag2) <= CMP_BITS'(thresh_ff);
      take_best = in_run_ff && (!best_valid_ff || (run_dur_ff > best_dur_ff));
      do_close  = cmd.close_run;

      seen_any_in   = seen_any_ff;
      acc_cnt_in    = acc_cnt_ff;
      in_run_in     = in_run_ff;
      best_valid_in = best_valid_ff;
      drop_cnt_in   = drop_cnt_ff;
      prev_time_in  = prev_time_ff;
      run_start_in  = run_start_ff;
      run_dur_in    = run_dur_ff;
      run_sum_x_in  = run_sum_x_ff;
      run_sum_y_in  = run_sum_y_ff;
      run_sum_z_in  = run_sum_z_ff;
      run_len_in    = run_len_ff;
      best_dur_in   = best_dur_ff;
      best_sum_x_in = best_sum_x_ff;
      best_sum_y_in = best_sum_y_ff;
      best_sum_z_in = best_sum_z_ff;
      best_len_in   = best_len_ff;

      if (cmd.update) begin
         if (drop) begin
            drop_cnt_in = sat_inc(drop_cnt_ff);
         end else begin
            prev_time_in = ts_ff;
            seen_any_in  = 1'b1;
            if (acc_cnt_ff != ACC_FULL)
               acc_cnt_in = acc_cnt_ff + 1'b1;
            if (quiet) begin
               // open a fresh run or extend the current one
               in_run_in    = 1'b1;
               run_start_in = in_run_ff ? run_start_ff : ts_ff;
               run_dur_in   = in_run_ff ? (ts_ff - run_start_ff) : '0;
               run_sum_x_in = sat_add(in_run_ff ? run_sum_x_ff : '0, gx_ff);
               run_sum_y_in = sat_add(in_run_ff ? run_sum_y_ff : '0, gy_ff);
               run_sum_z_in = sat_add(in_run_ff ? run_sum_z_ff : '0, gz_ff);
               run_len_in   = sat_inc(in_run_ff ? run_len_ff : '0);
            end else begin
               do_close = 1'b1;
            end
         end
      end

      if (do_close) begin
         if (take_best) begin
            best_valid_in = 1'b1;
            best_dur_in   = run_dur_ff;
            best_sum_x_in = run_sum_x_ff;
            best_sum_y_in = run_sum_y_ff;
            best_sum_z_in = run_sum_z_ff;
            best_len_in   = run_len_ff;
         end
         in_run_in = 1'b0;
      end

      if (cmd.emit) begin
         seen_any_in   = 1'b0;
         acc_cnt_in    = '0;
         in_run_in     = 1'b0;
         best_valid_in = 1'b0;
         drop_cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff   <= 1'b0;
         acc_cnt_ff    <= '0;
         in_run_ff     <= 1'b0;
         best_valid_ff <= 1'b0;
         drop_cnt_ff   <= '0;
      end else begin
         seen_any_ff   <= seen_any_in;
         acc_cnt_ff    <= acc_cnt_in;
         in_run_ff     <= in_run_in;
         best_valid_ff <= best_valid_in;
         drop_cnt_ff   <= drop_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_time_ff  <= prev_time_in;
      run_start_ff  <= run_start_in;
      run_dur_ff    <= run_dur_in;
      run_sum_x_ff  <= run_sum_x_in;
      run_sum_y_ff  <= run_sum_y_in;
      run_sum_z_ff  <= run_sum_z_in;
      run_len_ff    <= run_len_in;
      best_dur_ff   <= best_dur_in;
      best_sum_x_ff <= best_sum_x_in;
      best_sum_y_ff <= best_sum_y_in;
      best_sum_z_ff <= best_sum_z_in;
      best_len_ff   <= best_len_in;
   end

   // status is tested in priority order: few samples, no run, too short
   always_comb begin
      if (acc_cnt_ff != ACC_FULL)
         status_code = STATUS_FEW;
      else if (!best_valid_ff)
         status_code = STATUS_NO_QUIET;
      else if (best_dur_ff < TIME_BITS'(min_dur_ff))
         status_code = STATUS_SHORT;
      else
         status_code = STATUS_OK;
   end

   // divider operand for the axis in progress
   always_comb begin
      case (cmd.axis)
         AXIS_X:  sel_sum = best_sum_x_ff;
         AXIS_Y:  sel_sum = best_sum_y_ff;
         AXIS_Z:  sel_sum = best_sum_z_ff;
         default: sel_sum = best_sum_x_ff;
      endcase
      sel_mag = sel_sum[SUM_BITS-1] ? ('0 - $unsigned(sel_sum)) : $unsigned(sel_sum);
   end

   gsbf_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sel_mag),
      .divisor  (best_len_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // restore sign and clamp to the sample range
   always_comb begin
      if (sel_sum[SUM_BITS-1])
         bias_in = (quotient > NEG_LIMIT) ? BIAS_MIN : ('0 - quotient[SAMPLE_BITS-1:0]);
      else
         bias_in = (quotient > POS_LIMIT) ? BIAS_MAX : quotient[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.bias_store) begin
         case (cmd.axis)
            AXIS_X:  bias_x_ff <= bias_in;
            AXIS_Y:  bias_y_ff <= bias_in;
            AXIS_Z:  bias_z_ff <= bias_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= status_code;
         if (status_code == STATUS_OK) begin
            rsp_bias_x_ff <= bias_x_ff;
            rsp_bias_y_ff <= bias_y_ff;
            rsp_bias_z_ff <= bias_z_ff;
            rsp_len_ff    <= best_len_ff;
            rsp_dur_ff    <= best_dur_ff;
            rsp_drop_ff   <= drop_cnt_ff;
         end else begin
            rsp_bias_x_ff <= '0;
            rsp_bias_y_ff <= '0;
            rsp_bias_z_ff <= '0;
            rsp_len_ff    <= '0;
            rsp_dur_ff    <= '0;
            rsp_drop_ff   <= '0;
         end
      end
   end

   assign sts.last_item = last_ff;
   assign sts.result_ok = (status_code == STATUS_OK);
   assign sts.div_done  = div_done;

   assign out_status          = rsp_status_ff;
   assign out_bias_x          = rsp_bias_x_ff;
   assign out_bias_y          = rsp_bias_y_ff;
   assign out_bias_z          = rsp_bias_z_ff;
   assign out_run_samples     = rsp_len_ff;
   assign out_run_duration    = rsp_dur_ff;
   assign out_dropped_samples = rsp_drop_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gsbf_ctrl.sv @@
// Controller state machine: sequences capture, update, run close, the three
// divisions and the result hand-off. Uses gsbf_pkg.
`default_nettype none

module gsbf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output gsbf_pkg::gsbf_cmd_type cmd,
   input  gsbf_pkg::gsbf_sts_type sts
);

   import gsbf_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_UPDATE    = 3'd1;
   localparam logic [2:0] ST_CLOSE     = 3'd2;
   localparam logic [2:0] ST_CHECK     = 3'd3;
   localparam logic [2:0] ST_DIV_START = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd5;
   localparam logic [2:0] ST_EMIT      = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [AXIS_BITS-1:0] axis_ff, axis_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = sts.last_item ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            cmd.close_run = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            axis_in  = AXIS_X;
            state_in = sts.result_ok ? ST_DIV_START : ST_EMIT;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.bias_store = 1'b1;
               case (axis_ff)
                  AXIS_X: begin
                     axis_in  = AXIS_Y;
                     state_in = ST_DIV_START;
                  end
                  AXIS_Y: begin
                     axis_in  = AXIS_Z;
                     state_in = ST_DIV_START;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_EMIT: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.axis = axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid) |=> (state_ff == ST_UPDATE))
      else $error("accepted item not followed by update");

   a_emit_into_free_reg: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites an untaken result");

   a_bad_status_skips_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !sts.result_ok) |=> (state_ff == ST_EMIT))
      else $error("non-ok status entered division");

   a_div_done_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT && sts.div_done)
         |=> (state_ff == ST_DIV_START || state_ff == ST_EMIT))
      else $error("divider completion not acted on");
`endif

endmodule

`default_nettype wire
